### sv/ppc_pkg.sv
// Package with shared sizes, types and constant tables of the pattern census.
package ppc_pkg;
    localparam int MAX_PERM_LEN    = 10;
    localparam int MAX_PATTERN_LEN = 6;
    localparam int PAT_DEPTH       = 720;
    localparam int PAT_AW          = 10;
    localparam int CNT_W           = 22;
    localparam int PIDX_W          = 4;
    localparam int SEEN_W          = 22;

    localparam logic [2:0] ADDR_PERM_LEN = 3'h0;
    localparam logic [2:0] ADDR_PAT_LEN  = 3'h4;

    typedef logic [PIDX_W-1:0] val_t;

    typedef struct packed {
        logic [CNT_W-1:0] total_perms;
        logic [CNT_W-1:0] identity_count;
        logic [CNT_W-1:0] max_count;
        logic [9:0]       argmax_rank;
        logic [23:0]      argmax_pattern;
        logic [9:0]       better_count;
        logic [9:0]       pattern_total;
    } result_t;

    function automatic logic [CNT_W-1:0] fact(input logic [3:0] x);
        logic [CNT_W-1:0] f;
        unique case (x)
            4'd0, 4'd1: f = 22'd1;
            4'd2:  f = 22'd2;
            4'd3:  f = 22'd6;
            4'd4:  f = 22'd24;
            4'd5:  f = 22'd120;
            4'd6:  f = 22'd720;
            4'd7:  f = 22'd5040;
            4'd8:  f = 22'd40320;
            4'd9:  f = 22'd362880;
            4'd10: f = 22'd3628800;
            default: f = 22'd0;
        endcase
        return f;
    endfunction
endpackage

### sv/ppc_count_ram.sv
// Pattern store: per-pattern count and the number of the permutation that last marked it.
module ppc_count_ram (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [ppc_pkg::PAT_AW-1:0] waddr,
    input  logic [ppc_pkg::CNT_W-1:0]  wcount,
    input  logic [ppc_pkg::SEEN_W-1:0] wseen,
    input  logic [ppc_pkg::PAT_AW-1:0] raddr,
    output logic [ppc_pkg::CNT_W-1:0]  rcount,
    output logic [ppc_pkg::SEEN_W-1:0] rseen
);
    import ppc_pkg::*;

    logic [CNT_W+SEEN_W-1:0] mem [PAT_DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= {wcount, wseen};
        end
        {rcount, rseen} <= mem[raddr];
    end
endmodule

### sv/ppc_decode.sv
// Sequential decoder of a pattern rank into its digits, one digit per cycle.
module ppc_decode (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [2:0]                k,
    input  logic [ppc_pkg::PAT_AW-1:0] rank,
    output logic                      done,
    output logic [23:0]               digits
);
    import ppc_pkg::*;

    logic [PAT_AW-1:0] rem_reg, rem_next;
    logic [2:0]        i_reg, i_next;
    logic [5:0]        used_reg, used_next;
    logic [23:0]       dig_reg, dig_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    always_comb begin
        logic [CNT_W-1:0] f;
        logic [2:0] c, v;
        logic       found;
        rem_next = rem_reg; i_next = i_reg; used_next = used_reg; dig_next = dig_reg;
        busy_next = busy_reg; done_next = 1'b0;
        f = fact(4'(k - 3'd1 - i_reg));
        c = 3'd0; v = 3'd0; found = 1'b0;
        if (start) begin
            rem_next = rank; i_next = 3'd0; used_next = '0; dig_next = '0; busy_next = 1'b1;
        end else if (busy_reg) begin
            // The quotient is below k, so trial multiples q*f for q from 1 to 5 find it.
            for (int q = 1; q < MAX_PATTERN_LEN; q++) begin
                if ({12'd0, rem_reg} >= 22'(q) * f) c = 3'(q);
            end
            rem_next = PAT_AW'({12'd0, rem_reg} - 22'(c) * f);
            for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
                if (!found && !used_reg[j]) begin
                    if (c == 3'd0) begin
                        v = 3'(j); found = 1'b1;
                    end else begin
                        c = c - 3'd1;
                    end
                end
            end
            used_next[v] = 1'b1;
            dig_next[4*i_reg +: 4] = {1'b0, v} + 4'd1;
            i_next = i_reg + 3'd1;
            if (i_reg == k - 3'd1) begin
                busy_next = 1'b0; done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next; i_reg <= i_next; used_reg <= used_next; dig_reg <= dig_next;
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next;
        end
    end

    assign done   = done_reg;
    assign digits = dig_reg;
endmodule

### sv/ppc_engine.sv
// Census sequencer: store clearing, permutation and subset stepping, ranking, store updates, summary scan and decode.
module ppc_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [3:0]        n_cfg,
    input  logic [2:0]        k_cfg,
    output logic              busy,
    output logic              res_valid,
    input  logic              res_take,
    output ppc_pkg::result_t  res
);
    import ppc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_PERM, S_RANK, S_READ, S_UPD, S_SUBNEXT, S_PERMNEXT,
        S_SCAN0, S_SCAN, S_DEC, S_OUT
    } state_t;

    state_t state_reg;
    logic [3:0] n_reg;
    logic [2:0] k_reg;
    val_t perm_reg [MAX_PERM_LEN];
    val_t pos_reg [MAX_PATTERN_LEN];
    logic [2:0] ri_reg;
    logic [PAT_AW-1:0] rank_reg, addr_reg;
    logic [CNT_W-1:0] total_reg, idc_reg, mx_reg;
    logic [PAT_AW-1:0] arg_reg, better_reg;
    logic [PAT_AW:0] scan_reg;
    logic scan_v_reg;
    logic [PAT_AW-1:0] scan_a_reg;
    logic dec_start_reg;
    result_t res_reg;
    logic res_valid_reg;

    logic we;
    logic [PAT_AW-1:0] waddr, raddr;
    logic [CNT_W-1:0] wcount, rcount;
    logic [SEEN_W-1:0] wseen, rseen;
    logic dec_done;
    logic [23:0] dec_digits;
    logic [CNT_W-1:0] npat;

    ppc_count_ram u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wcount(wcount), .wseen(wseen),
        .raddr(raddr), .rcount(rcount), .rseen(rseen)
    );

    ppc_decode u_dec (
        .aclk(aclk), .aresetn(aresetn), .start(dec_start_reg), .k(k_reg),
        .rank(arg_reg), .done(dec_done), .digits(dec_digits)
    );

    assign npat = fact({1'b0, k_reg});

    // Rank contribution of one chosen position: smaller later values times factorial.
    logic [PAT_AW-1:0] rank_add;
    always_comb begin
        logic [2:0] c;
        val_t vi;
        c = 3'd0;
        vi = perm_reg[pos_reg[ri_reg]];
        for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
            if (3'(j) > ri_reg && 3'(j) < k_reg && perm_reg[pos_reg[j]] < vi) c = c + 3'd1;
        end
        rank_add = PAT_AW'(22'(c) * fact(4'(k_reg - 3'd1 - ri_reg)));
    end

    // Next subset pointer.
    logic sub_ok;
    logic [2:0] sub_i;
    always_comb begin
        sub_ok = 1'b0; sub_i = 3'd0;
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
            if (3'(i) < k_reg && {1'b0, pos_reg[i]} != 5'(n_reg - {1'b0, k_reg} + 4'(i))) begin
                sub_ok = 1'b1; sub_i = 3'(i);
            end
        end
    end

    // Next permutation pivot and swap partner.
    logic perm_ok;
    logic [3:0] piv, swp;
    always_comb begin
        perm_ok = 1'b0; piv = 4'd0; swp = 4'd0;
        for (int i = 0; i < MAX_PERM_LEN - 1; i++) begin
            if (4'(i) + 4'd2 <= n_reg && perm_reg[i] < perm_reg[i+1]) begin
                perm_ok = 1'b1; piv = 4'(i);
            end
        end
        for (int j = 0; j < MAX_PERM_LEN; j++) begin
            if (4'(j) > piv && 4'(j) < n_reg && perm_reg[j] > perm_reg[piv]) swp = 4'(j);
        end
    end

    always_comb begin
        we = 1'b0; waddr = addr_reg; wcount = rcount + 22'd1; wseen = total_reg;
        raddr = rank_reg;
        if (state_reg == S_CLEAR) begin
            we = 1'b1; wcount = '0; wseen = '0;
        end else if (state_reg == S_UPD && rseen != total_reg) begin
            we = 1'b1;
        end
        if (state_reg == S_SCAN0 || state_reg == S_SCAN) raddr = scan_reg[PAT_AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_start_reg <= 1'b0;
        end else begin
            dec_start_reg <= (state_reg == S_SCAN) && ({11'd0, scan_reg} > npat);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            res_valid_reg <= 1'b0;
        end else begin
            if (state_reg == S_OUT && (!res_valid_reg || res_take)) begin
                res_valid_reg <= 1'b1;
            end else if (res_take) begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        n_reg <= (n_cfg == 4'd0) ? 4'd1 : (n_cfg > 4'd10 ? 4'd10 : n_cfg);
                        k_reg <= (k_cfg == 3'd0) ? 3'd1 : (k_cfg > 3'd6 ? 3'd6 : k_cfg);
                        addr_reg <= '0; total_reg <= '0;
                        for (int i = 0; i < MAX_PERM_LEN; i++) perm_reg[i] <= val_t'(i);
                        state_reg <= S_CLEAR;
                    end
                end
                S_CLEAR: begin
                    addr_reg <= addr_reg + 1'b1;
                    if (addr_reg == PAT_AW'(PAT_DEPTH - 1)) state_reg <= S_PERM;
                end
                S_PERM: begin
                    total_reg <= total_reg + 22'd1;
                    for (int i = 0; i < MAX_PATTERN_LEN; i++) pos_reg[i] <= val_t'(i);
                    ri_reg <= 3'd0; rank_reg <= '0;
                    state_reg <= ({1'b0, k_reg} <= n_reg) ? S_RANK : S_PERMNEXT;
                end
                S_RANK: begin
                    rank_reg <= rank_reg + rank_add;
                    ri_reg <= ri_reg + 3'd1;
                    if (ri_reg == k_reg - 3'd1) state_reg <= S_READ;
                end
                S_READ: begin
                    addr_reg <= rank_reg;
                    state_reg <= S_UPD;
                end
                S_UPD: state_reg <= S_SUBNEXT;
                S_SUBNEXT: begin
                    ri_reg <= 3'd0; rank_reg <= '0;
                    if (sub_ok) begin
                        for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
                            if (3'(j) == sub_i) pos_reg[j] <= pos_reg[j] + 4'd1;
                            else if (3'(j) > sub_i)
                                pos_reg[j] <= pos_reg[sub_i] + 4'd1 + 4'(3'(j) - sub_i);
                        end
                        state_reg <= S_RANK;
                    end else begin
                        state_reg <= S_PERMNEXT;
                    end
                end
                S_PERMNEXT: begin
                    if (perm_ok) begin
                        for (int a = 0; a < MAX_PERM_LEN; a++) begin
                            if (4'(a) == piv) perm_reg[a] <= perm_reg[swp];
                            else if (4'(a) > piv && 4'(a) < n_reg) begin
                                if (n_reg - 4'd1 + piv + 4'd1 - 4'(a) == swp)
                                    perm_reg[a] <= perm_reg[piv];
                                else perm_reg[a] <= perm_reg[n_reg + piv - 4'(a)];
                            end
                        end
                        state_reg <= S_PERM;
                    end else begin
                        scan_reg <= '0; scan_v_reg <= 1'b0;
                        mx_reg <= '0; arg_reg <= '0; better_reg <= '0;
                        state_reg <= S_SCAN0;
                    end
                end
                S_SCAN0: begin
                    scan_reg <= scan_reg + 1'b1; scan_a_reg <= '0; scan_v_reg <= 1'b1;
                    state_reg <= S_SCAN;
                end
                S_SCAN: begin
                    if (scan_v_reg) begin
                        if (scan_a_reg == '0) idc_reg <= rcount;
                        if (rcount > mx_reg) begin
                            mx_reg <= rcount; arg_reg <= scan_a_reg;
                        end
                        if (scan_a_reg != '0 && rcount > idc_reg) better_reg <= better_reg + 1'b1;
                    end
                    scan_a_reg <= scan_reg[PAT_AW-1:0];
                    scan_v_reg <= ({11'd0, scan_reg} < npat);
                    scan_reg <= scan_reg + 1'b1;
                    if ({11'd0, scan_reg} > npat) state_reg <= S_DEC;
                end
                S_DEC: begin
                    if (dec_done) state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!res_valid_reg || res_take) begin
                        res_reg.total_perms    <= total_reg;
                        res_reg.identity_count <= idc_reg;
                        res_reg.max_count      <= mx_reg;
                        res_reg.argmax_rank    <= arg_reg;
                        res_reg.argmax_pattern <= dec_digits;
                        res_reg.better_count   <= better_reg;
                        res_reg.pattern_total  <= npat[9:0];
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
endmodule

### sv/permutation_pattern_census.sv
// Top level of the permutation pattern census with stream ports and register port.
// Flow: the 720-entry store is cleared, then every permutation is stepped and each of its
// k-subsets is ranked and counted, then the store is scanned, the argmax rank is decoded
// and the result is output.
// Throughput: one census at a time; a finished census waits while the previous result
// transfer is pending, and the input stays stalled until it can be handed over.
// Reset: aresetn is synchronous and active low; registers return to n=4, k=3.
// The pattern store is cleared by a sweep at the start of every census.
module permutation_pattern_census (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [119:0] m_tdata   // total_perms, identity_count, max_count, argmax_rank,
                                   // argmax_pattern, better_count, pattern_total
);
    import ppc_pkg::*;

    logic [3:0] n_reg;
    logic [2:0] k_reg;
    logic busy;
    result_t res;
    logic start;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg <= 4'd4; k_reg <= 3'd3;
        end else if (psel && penable && pwrite) begin
            if (paddr == ADDR_PERM_LEN) n_reg <= pwdata[3:0];
            if (paddr == ADDR_PAT_LEN)  k_reg <= pwdata[2:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_PERM_LEN) prdata = {28'd0, n_reg};
        else if (paddr == ADDR_PAT_LEN) prdata = {29'd0, k_reg};
    end
    assign pready = 1'b1;

    assign s_tready = !busy;
    assign start = s_tvalid && s_tready && s_tdata[0];

    ppc_engine u_eng (
        .aclk(aclk), .aresetn(aresetn), .start(start), .n_cfg(n_reg), .k_cfg(k_reg),
        .busy(busy), .res_valid(m_tvalid), .res_take(m_tready), .res(res)
    );

    assign m_tdata = {res.pattern_total, res.better_count, res.argmax_pattern,
                      res.argmax_rank, res.max_count, res.identity_count, res.total_perms};
endmodule
